### hw/rtl/iss_pkg.sv
`default_nettype none

package iss_pkg;

  localparam int CAPACITY = 128;
  localparam int ELEM_W   = 8;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 8;
  localparam int FP_W     = 7;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_FIND   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_CLEAR,
    CELL_SCAN
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic              find;
    logic [POS_W-1:0]  pos;
    logic [ELEM_W-1:0] value;
    logic [CNT_W-1:0]  count;
  } cell_ctrl_t;

  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  idx;
    logic [ELEM_W-1:0] value;
  } cell_res_t;

endpackage

`default_nettype wire

### hw/rtl/iss_cell.sv
`default_nettype none

module iss_cell (
  input  wire logic                       clk,
  input  wire iss_pkg::cell_ctrl_t        ctrl,
  input  wire logic [iss_pkg::IDX_W-1:0]  cell_idx,
  input  wire logic [iss_pkg::ELEM_W-1:0] left_entry,
  input  wire logic [iss_pkg::ELEM_W-1:0] right_entry,
  input  wire iss_pkg::cell_res_t         right_res,
  output logic [iss_pkg::ELEM_W-1:0]      entry,
  output iss_pkg::cell_res_t              res
);
  import iss_pkg::*;

  logic [ELEM_W-1:0] entry_r, entry_nxt;
  cell_res_t         res_r, res_nxt;
  logic [POS_W-1:0]  k_pos;
  logic              live;
  logic              hit;

  always_comb begin
    k_pos     = POS_W'(cell_idx);
    live      = CNT_W'(cell_idx) < ctrl.count;
    hit       = live && (ctrl.find ? (entry_r == ctrl.value) : (k_pos == ctrl.pos));
    entry_nxt = entry_r;
    res_nxt   = res_r;
    unique case (ctrl.op)
      CELL_INSERT: begin
        if (k_pos > ctrl.pos) begin
          entry_nxt = left_entry;
        end else if (k_pos == ctrl.pos) begin
          entry_nxt = ctrl.value;
        end
      end
      CELL_DELETE: begin
        if (k_pos >= ctrl.pos) begin
          entry_nxt = right_entry;
        end
      end
      CELL_CLEAR: begin
        res_nxt = '0;
      end
      CELL_SCAN: begin
        if (hit) begin
          res_nxt.hit   = 1'b1;
          res_nxt.idx   = cell_idx;
          res_nxt.value = entry_r;
        end else begin
          res_nxt = right_res;
        end
      end
      CELL_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    res_r   <= res_nxt;
  end

  assign entry = entry_r;
  assign res   = res_r;

endmodule

`default_nettype wire

### hw/rtl/indexed_sequence_store.sv
// Insert, delete and any rejected command: the result is registered on the transfer and valid in the next cycle.
// Read and find: a hit token ripples down the cell chain toward cell 0, one cell per cycle,
//   while the scan state steps through all CAPACITY cells; the done state then registers the result from cell 0.
// One command is in flight at a time; a new one is taken as the previous result leaves.
// Synchronous active-low reset empties the store (count zero); entry contents are not cleared.
`default_nettype none

module indexed_sequence_store (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // position[7:0], element_value[15:8]
  input  wire logic [1:0]  in_tuser,   // cmd[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // read_value[7:0], found_position[14:8],
                                       // entry_count[22:15], zero[23]
  output logic [1:0]       out_tuser   // status[1:0]
);
  import iss_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  scan_cnt_r, scan_cnt_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [ELEM_W-1:0] val_r, val_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           status_r, status_nxt;
  logic [ELEM_W-1:0] rd_r, rd_nxt;
  logic [FP_W-1:0]   fp_r, fp_nxt;
  logic [CNT_W-1:0]  cnt_out_r, cnt_out_nxt;

  logic              accept;
  cmd_t              in_cmd;
  logic [POS_W-1:0]  in_pos;
  logic [ELEM_W-1:0] in_val;
  cell_ctrl_t        ctrl;

  logic [ELEM_W-1:0] entry_w [CAPACITY];
  cell_res_t         res_w   [CAPACITY+1];

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign in_cmd    = cmd_t'(in_tuser);
  assign in_pos    = in_tdata[7:0];
  assign in_val    = in_tdata[15:8];

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    scan_cnt_nxt  = scan_cnt_r;
    cmd_nxt       = cmd_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r && !out_tready;
    status_nxt    = status_r;
    rd_nxt        = rd_r;
    fp_nxt        = fp_r;
    cnt_out_nxt   = cnt_out_r;
    ctrl.op       = CELL_HOLD;
    ctrl.find     = (cmd_r == CMD_FIND);
    ctrl.pos      = pos_r;
    ctrl.value    = val_r;
    ctrl.count    = count_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          ctrl.pos      = in_pos;
          ctrl.value    = in_val;
          rd_nxt        = '0;
          fp_nxt        = '0;
          status_nxt    = ST_OK;
          out_valid_nxt = 1'b1;
          unique case (in_cmd)
            CMD_INSERT: begin
              if (in_pos > POS_W'(count_r)) begin
                status_nxt = ST_RANGE;
              end else if (count_r == CNT_W'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else begin
                ctrl.op   = CELL_INSERT;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_DELETE: begin
              if (in_pos >= POS_W'(count_r)) begin
                status_nxt = ST_RANGE;
              end else begin
                ctrl.op   = CELL_DELETE;
                count_nxt = count_r - CNT_W'(1);
              end
            end
            CMD_READ, CMD_FIND: begin
              if (in_cmd == CMD_READ && in_pos >= POS_W'(count_r)) begin
                status_nxt = ST_RANGE;
              end else begin
                out_valid_nxt = 1'b0;
                ctrl.op       = CELL_CLEAR;
                cmd_nxt       = in_cmd;
                pos_nxt       = in_pos;
                val_nxt       = in_val;
                scan_cnt_nxt  = '0;
                state_nxt     = S_SCAN;
              end
            end
            default: begin
            end
          endcase
          cnt_out_nxt = count_nxt;
        end
      end
      S_SCAN: begin
        ctrl.op      = CELL_SCAN;
        scan_cnt_nxt = scan_cnt_r + IDX_W'(1);
        if (scan_cnt_r == IDX_W'(CAPACITY - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        cnt_out_nxt   = count_r;
        status_nxt    = res_w[0].hit ? ST_OK : ST_NOTFOUND;
        rd_nxt        = (cmd_r == CMD_READ && res_w[0].hit) ? res_w[0].value : '0;
        fp_nxt        = (cmd_r == CMD_FIND && res_w[0].hit) ? FP_W'(res_w[0].idx) : '0;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_cnt_r <= scan_cnt_nxt;
    cmd_r      <= cmd_nxt;
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    status_r   <= status_nxt;
    rd_r       <= rd_nxt;
    fp_r       <= fp_nxt;
    cnt_out_r  <= cnt_out_nxt;
  end

  assign res_w[CAPACITY] = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ELEM_W-1:0] left_w;
    logic [ELEM_W-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = ctrl.value;
    end else begin : g_mid
      assign left_w = entry_w[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = entry_w[g];
    end else begin : g_inner
      assign right_w = entry_w[g+1];
    end
    iss_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .cell_idx    (IDX_W'(g)),
      .left_entry  (left_w),
      .right_entry (right_w),
      .right_res   (res_w[g+1]),
      .entry       (entry_w[g]),
      .res         (res_w[g])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {1'b0, cnt_out_r, fp_r, rd_r};

endmodule

`default_nettype wire

### dv/tb_indexed_sequence_store.sv
`timescale 1ns / 1ps

module tb_indexed_sequence_store;
  import iss_pkg::*;

  typedef struct packed {
    cmd_t              cmd;
    logic [POS_W-1:0]  pos;
    logic [ELEM_W-1:0] value;
  } store_cmd_t;

  typedef struct packed {
    status_t           status;
    logic [ELEM_W-1:0] read_value;
    logic [FP_W-1:0]   found_pos;
    logic [7:0]        entry_count;
  } store_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;

  store_cmd_t        cmd_queue[$];
  store_result_t     result_queue[$];
  logic [ELEM_W-1:0] shadow_entries[CAPACITY];
  int                shadow_count = 0;
  int                gen_count = 0;
  bit                gen_growing = 1'b1;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  logic              recv_hold = 1'b0;
  int                errors = 0;

  indexed_sequence_store u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  function automatic store_result_t apply_store_cmd(store_cmd_t c);
    store_result_t r;
    r = '0;
    r.status = ST_OK;
    case (c.cmd)
      CMD_INSERT: begin
        if (c.pos > shadow_count) begin
          r.status = ST_RANGE;
        end else if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int k = shadow_count; k > c.pos; k--) shadow_entries[k] = shadow_entries[k-1];
          shadow_entries[c.pos] = c.value;
          shadow_count++;
        end
      end
      CMD_DELETE: begin
        if (c.pos >= shadow_count) begin
          r.status = ST_RANGE;
        end else begin
          for (int k = c.pos; k + 1 < shadow_count; k++) shadow_entries[k] = shadow_entries[k+1];
          shadow_count--;
        end
      end
      CMD_READ: begin
        if (c.pos >= shadow_count) begin
          r.status = ST_RANGE;
        end else begin
          r.read_value = shadow_entries[c.pos];
        end
      end
      default: begin
        r.status = ST_NOTFOUND;
        for (int k = 0; k < shadow_count; k++) begin
          if (r.status == ST_NOTFOUND && shadow_entries[k] == c.value) begin
            r.status = ST_OK;
            r.found_pos = FP_W'(k);
          end
        end
      end
    endcase
    r.entry_count = 8'(shadow_count);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // tracks only the count, to steer positions during generation
  task automatic queue_cmd(cmd_t op, int pos, int val);
    store_cmd_t c;
    c.cmd = op;
    c.pos = 8'(pos);
    c.value = 8'(val);
    if (op == CMD_INSERT && c.pos <= gen_count && gen_count < CAPACITY) gen_count++;
    if (op == CMD_DELETE && c.pos < gen_count) gen_count--;
    cmd_queue.push_back(c);
  endtask

  task automatic queue_random_cmds(int n);
    int   r;
    int   rp;
    int   pos;
    int   val;
    cmd_t op;
    repeat (n) begin
      if (gen_count == CAPACITY && $urandom_range(0, 7) == 0) gen_growing = 1'b0;
      if (gen_count == 0 && $urandom_range(0, 3) == 0) gen_growing = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 12) op = CMD_READ;
      else if (r < 24) op = CMD_FIND;
      else if (r < (gen_growing ? 87 : 37)) op = CMD_INSERT;
      else op = CMD_DELETE;
      val = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 15) : $urandom_range(0, 255);
      rp = $urandom_range(0, 99);
      if (rp < 8) pos = $urandom_range(0, 255);
      else if (rp < 18) pos = 0;
      else if (rp < 28) pos = (op == CMD_INSERT || gen_count == 0) ? gen_count : gen_count - 1;
      else if (rp < 33) pos = gen_count;
      else if (op == CMD_INSERT) pos = $urandom_range(0, gen_count);
      else pos = (gen_count > 0) ? $urandom_range(0, gen_count - 1) : 0;
      queue_cmd(op, pos, val);
    end
  endtask

  // sampled on the falling edge, after every rising-edge update has settled
  task automatic wait_drained();
    while (cmd_queue.size() != 0 || in_tvalid || result_queue.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin : drive_proc
    store_cmd_t nxt;
    store_cmd_t seen;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        seen.cmd = cmd_t'(in_tuser);
        seen.pos = in_tdata[7:0];
        seen.value = in_tdata[15:8];
        result_queue.push_back(apply_store_cmd(seen));
      end
      if (!in_tvalid || in_tready) begin
        if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = cmd_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {nxt.value, nxt.pos};
          in_tuser <= nxt.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_proc
    store_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (result_queue.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer, expected none, actual tuser %0h tdata %0h",
                   $time, out_tuser, out_tdata);
        end else begin
          want = result_queue.pop_front();
          check_field("status", want.status, out_tuser);
          check_field("read_value", want.read_value, out_tdata[7:0]);
          check_field("found_position", want.found_pos, out_tdata[14:8]);
          check_field("entry_count", want.entry_count, out_tdata[22:15]);
          check_field("pad", 0, out_tdata[23]);
        end
      end
      out_tready <= !recv_hold && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    #60_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // empty store
    queue_cmd(CMD_READ, 0, 0);
    queue_cmd(CMD_DELETE, 0, 0);
    queue_cmd(CMD_FIND, 0, 0);
    queue_cmd(CMD_INSERT, 1, 5);
    queue_cmd(CMD_INSERT, 255, 0);
    // front, back and middle inserts, then finds, reads and deletes at in-range and out-of-range positions
    queue_cmd(CMD_INSERT, 0, 8'h00);
    queue_cmd(CMD_INSERT, 1, 8'hFF);
    queue_cmd(CMD_INSERT, 0, 8'hA5);
    queue_cmd(CMD_INSERT, 1, 8'h5A);
    queue_cmd(CMD_INSERT, 4, 8'hFF);
    queue_cmd(CMD_FIND, 0, 8'hFF);
    queue_cmd(CMD_FIND, 7, 8'h77);
    queue_cmd(CMD_READ, 0, 0);
    queue_cmd(CMD_READ, 4, 0);
    queue_cmd(CMD_READ, 5, 0);
    queue_cmd(CMD_READ, 128, 0);
    queue_cmd(CMD_DELETE, 2, 0);
    queue_cmd(CMD_DELETE, 0, 0);
    queue_cmd(CMD_DELETE, gen_count - 1, 0);
    queue_cmd(CMD_DELETE, 200, 0);
    queue_cmd(CMD_INSERT, 128, 8'h80);
    queue_cmd(CMD_FIND, 0, 8'h00);
    queue_cmd(CMD_READ, 1, 0);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 48 : (ph == 3) ? 29 : 0;
      recv_stall_pct = (ph == 2) ? 48 : (ph == 3) ? 29 : 0;
      queue_random_cmds(308);
      if (ph == 0) begin
        repeat (40) @(posedge clk);
        recv_hold <= 1'b1;
        repeat (400) @(posedge clk);
        recv_hold <= 1'b0;
      end
      wait_drained();
    end

    repeat (140) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
